FILE: src/spa_pkg.sv
// Shared types and constants for the sorted pitch alignment block.
// No dependencies.
package spa_pkg;
  localparam int MAX_VOICES = 16;
  localparam logic [1:0] OP_LOAD_OLD = 2'd0;
  localparam logic [1:0] OP_LOAD_NEW = 2'd1;
  localparam logic [1:0] OP_COMPUTE  = 2'd2;
  localparam logic [1:0] PICK_SKIP_OLD = 2'd0;
  localparam logic [1:0] PICK_SKIP_NEW = 2'd1;
  localparam logic [1:0] PICK_MATCH    = 2'd2;
  localparam int PITCH_W = 16;
  typedef logic [PITCH_W-1:0] pitch_t;
endpackage

FILE: src/spa_cell.sv
// One column cell of the alignment table row: holds match count, cost and choice.
// Depends on spa_pkg.
module spa_cell import spa_pkg::*; #(
  parameter int MW = 5,
  parameter int CW = 20
) (
  input  logic          clk,
  input  logic          en,
  input  logic          i_ok,
  input  logic          j_ok,
  input  logic          corner,
  input  logic [MW-1:0] below_m,
  input  logic [CW-1:0] below_c,
  input  logic [MW-1:0] right_m,
  input  logic [CW-1:0] right_c,
  input  logic [MW-1:0] diag_m,
  input  logic [CW-1:0] diag_c,
  input  pitch_t        po,
  input  pitch_t        pn,
  output logic [MW-1:0] m_r,
  output logic [CW-1:0] c_r,
  output logic [1:0]    pick_r
);
  logic [MW-1:0] bm, cm;
  logic [CW-1:0] bc, cc;
  logic [1:0] bp;
  logic have;
  pitch_t d;
  always_comb begin
    bm = '0; bc = '0; bp = PICK_SKIP_OLD; have = 1'b0;
    d = (po > pn) ? po - pn : pn - po;
    cm = diag_m + MW'(1);
    cc = diag_c + CW'(d);
    if (i_ok) begin
      bm = below_m; bc = below_c; have = 1'b1;
    end
    if (j_ok && (!have || right_m > bm || (right_m == bm && right_c < bc))) begin
      bm = right_m; bc = right_c; bp = PICK_SKIP_NEW;
    end
    if (i_ok && j_ok && (cm > bm || (cm == bm && cc < bc))) begin
      bm = cm; bc = cc; bp = PICK_MATCH;
    end
    if (corner) begin
      bm = '0; bc = '0; bp = PICK_SKIP_OLD;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m_r <= bm; c_r <= bc; pick_r <= bp;
    end
  end
endmodule

FILE: src/sorted_pitch_alignment_dp.sv
// Sorted pitch alignment: loads two pitch lists, sorts, aligns by DP, traces back.
// Depends on spa_pkg and spa_cell.
//
// Usage: in_opcode/in_pitch transfer on in_valid && in_ready. A compute item
// sorts both lists (one compare-exchange pass a cycle), then sweeps the table one
// old row at a time from the last row up; a row of cells, one per new column,
// updates from its own previous values and the already-finished cells to its
// right, walking right to left one column a cycle. The table choices are kept in
// a memory. Traceback waits for the last choice write, and each of its steps
// waits for the memory read because that read is registered. One result per new
// voice then goes out on out_* with out_last on the final one. An empty list
// skips the sort and the table. in_ready is low while a compute runs and while
// a result waits. Reset clears counts and control. When the receiver stalls, the
// output register holds and the block waits.
module sorted_pitch_alignment_dp import spa_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic [1:0] in_opcode,
  input  logic [15:0] in_pitch,
  output logic out_valid,
  input  logic out_ready,
  output logic [3:0] out_new_index,
  output logic [3:0] out_old_index,
  output logic out_matched,
  output logic out_empty_res,
  output logic out_last
);
  localparam int IW = $clog2(MAX_VOICES + 1);
  localparam int XW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int MW = IW;
  localparam int CW = PITCH_W + IW;
  localparam int DIM = MAX_VOICES + 1;
  localparam int AW = $clog2(DIM * DIM);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SORT = 3'd1;
  localparam logic [2:0] S_FILL = 3'd2;
  localparam logic [2:0] S_TRACE = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0] st_r, st_nxt;
  logic [IW-1:0] oc_r, nc_r, m_r, q_r;
  pitch_t opit_r [MAX_VOICES];
  pitch_t npit_r [MAX_VOICES];
  logic [XW-1:0] oord_r [MAX_VOICES];
  logic [XW-1:0] nord_r [MAX_VOICES];
  logic [IW-1:0] cnt_r, i_r, j_r;
  logic [XW-1:0] match_r [MAX_VOICES];
  logic [MAX_VOICES-1:0] mv_r;
  logic [1:0] choice_mem [DIM*DIM];
  logic [1:0] rd_r;
  logic rd_ok_r;
  logic [MW-1:0] cm_w [DIM];
  logic [CW-1:0] cc_w [DIM];
  logic [1:0] cp_w [DIM];
  logic [MW-1:0] prev_m_r [DIM];
  logic [CW-1:0] prev_c_r [DIM];
  logic ov_r;
  logic [3:0] on_r, oo_r;
  logic om_r, oe_r, ol_r;
  logic out_free;

  assign out_free = !ov_r || out_ready;
  assign in_ready = (st_r == S_IDLE) && out_free;
  assign out_valid = ov_r;
  assign out_new_index = on_r;
  assign out_old_index = oo_r;
  assign out_matched = om_r;
  assign out_empty_res = oe_r;
  assign out_last = ol_r;

  // Cells: one per column; column j_r updates in the fill walk.
  genvar g;
  generate
    for (g = 0; g < DIM; g++) begin : g_col
      logic en;
      assign en = (st_r == S_FILL) && (j_r == IW'(g));
      if (g < MAX_VOICES) begin : g_in
        spa_cell #(.MW(MW), .CW(CW)) u_cell (
          .clk(clk), .en(en),
          .i_ok(i_r < m_r), .j_ok(IW'(g) < q_r),
          .corner(i_r == m_r && IW'(g) == q_r),
          .below_m(prev_m_r[g]), .below_c(prev_c_r[g]),
          .right_m(cm_w[g+1]), .right_c(cc_w[g+1]),
          .diag_m(prev_m_r[g+1]), .diag_c(prev_c_r[g+1]),
          .po(opit_r[oord_r[i_r[XW-1:0]]]), .pn(npit_r[nord_r[g]]),
          .m_r(cm_w[g]), .c_r(cc_w[g]), .pick_r(cp_w[g]));
      end else begin : g_edge
        spa_cell #(.MW(MW), .CW(CW)) u_cell (
          .clk(clk), .en(en),
          .i_ok(i_r < m_r), .j_ok(1'b0),
          .corner(i_r == m_r && IW'(g) == q_r),
          .below_m(prev_m_r[g]), .below_c(prev_c_r[g]),
          .right_m('0), .right_c('0), .diag_m('0), .diag_c('0),
          .po('0), .pn('0),
          .m_r(cm_w[g]), .c_r(cc_w[g]), .pick_r(cp_w[g]));
      end
    end
  endgenerate

  // Sort: odd-even transposition, stable by index on ties.
  logic [XW-1:0] oo_n [MAX_VOICES];
  logic [XW-1:0] no_n [MAX_VOICES];
  always_comb begin
    for (int k = 0; k < MAX_VOICES; k++) begin
      oo_n[k] = oord_r[k];
      no_n[k] = nord_r[k];
    end
    for (int k = 0; k + 1 < MAX_VOICES; k++) begin
      if ((k % 2) == int'(cnt_r[0])) begin
        if (IW'(k + 1) < m_r && (opit_r[oord_r[k]] > opit_r[oord_r[k+1]] ||
            (opit_r[oord_r[k]] == opit_r[oord_r[k+1]] && oord_r[k] > oord_r[k+1]))) begin
          oo_n[k] = oord_r[k+1]; oo_n[k+1] = oord_r[k];
        end
        if (IW'(k + 1) < q_r && (npit_r[nord_r[k]] > npit_r[nord_r[k+1]] ||
            (npit_r[nord_r[k]] == npit_r[nord_r[k+1]] && nord_r[k] > nord_r[k+1]))) begin
          no_n[k] = nord_r[k+1]; no_n[k+1] = nord_r[k];
        end
      end
    end
  end

  logic [AW-1:0] waddr, raddr;
  assign waddr = AW'(i_r) * AW'(DIM) + AW'(j_r);
  assign raddr = AW'(i_r) * AW'(DIM) + AW'(j_r);
  logic wr_pend_r;
  logic [AW-1:0] wa_r;
  logic [IW-1:0] wj_r;

  always_ff @(posedge clk) begin
    if (wr_pend_r) begin
      choice_mem[wa_r] <= cp_w[wj_r];
    end
    rd_r <= choice_mem[raddr];
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (in_valid && in_ready && in_opcode == OP_COMPUTE) begin
        st_nxt = (nc_r == '0) ? S_EMIT : (oc_r == '0) ? S_EMIT : S_SORT;
      end
      S_SORT: if (cnt_r == IW'(MAX_VOICES)) st_nxt = S_FILL;
      S_FILL: if (i_r == '0 && j_r == '0) st_nxt = S_TRACE;
      S_TRACE: if (rd_ok_r && (i_r >= m_r || j_r >= q_r)) st_nxt = S_EMIT;
      S_EMIT: if (out_free && (q_r == '0 || cnt_r + IW'(1) == q_r)) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; oc_r <= '0; nc_r <= '0; ov_r <= 1'b0;
      wr_pend_r <= 1'b0; rd_ok_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (ov_r && out_ready) ov_r <= 1'b0;
      wr_pend_r <= 1'b0;
      unique case (st_r)
        S_IDLE: if (in_valid && in_ready) begin
          if (in_opcode == OP_LOAD_OLD && oc_r < IW'(MAX_VOICES)) begin
            opit_r[oc_r[XW-1:0]] <= in_pitch; oc_r <= oc_r + IW'(1);
          end else if (in_opcode == OP_LOAD_NEW && nc_r < IW'(MAX_VOICES)) begin
            npit_r[nc_r[XW-1:0]] <= in_pitch; nc_r <= nc_r + IW'(1);
          end else if (in_opcode == OP_COMPUTE) begin
            m_r <= oc_r; q_r <= nc_r; oc_r <= '0; nc_r <= '0;
            cnt_r <= '0; mv_r <= '0; i_r <= oc_r; j_r <= IW'(MAX_VOICES);
            for (int k = 0; k < MAX_VOICES; k++) begin
              oord_r[k] <= XW'(k); nord_r[k] <= XW'(k);
            end
          end
        end
        S_SORT: begin
          for (int k = 0; k < MAX_VOICES; k++) begin
            oord_r[k] <= oo_n[k]; nord_r[k] <= no_n[k];
          end
          cnt_r <= cnt_r + IW'(1);
        end
        S_FILL: begin
          if (j_r <= q_r) begin
            wr_pend_r <= 1'b1; wa_r <= waddr; wj_r <= j_r;
          end
          if (j_r == IW'(MAX_VOICES)) begin
            prev_m_r[0] <= cm_w[0];
            prev_c_r[0] <= cc_w[0];
          end
          if (j_r == '0) begin
            for (int k = 1; k < DIM; k++) begin
              prev_m_r[k] <= cm_w[k];
              prev_c_r[k] <= cc_w[k];
            end
            if (i_r != '0) begin
              i_r <= i_r - IW'(1); j_r <= IW'(MAX_VOICES);
            end
          end else begin
            j_r <= j_r - IW'(1);
          end
          if (st_nxt == S_TRACE) rd_ok_r <= 1'b0;
        end
        S_TRACE: begin
          rd_ok_r <= !rd_ok_r && !wr_pend_r;
          if (rd_ok_r && i_r < m_r && j_r < q_r) begin
            if (rd_r == PICK_SKIP_OLD) begin
              i_r <= i_r + IW'(1);
            end else if (rd_r == PICK_SKIP_NEW) begin
              j_r <= j_r + IW'(1);
            end else begin
              match_r[nord_r[j_r[XW-1:0]]] <= oord_r[i_r[XW-1:0]];
              mv_r[nord_r[j_r[XW-1:0]]] <= 1'b1;
              i_r <= i_r + IW'(1); j_r <= j_r + IW'(1);
            end
          end
          if (st_nxt == S_EMIT) cnt_r <= '0;
        end
        S_EMIT: if (out_free) begin
          ov_r <= 1'b1;
          if (q_r == '0) begin
            on_r <= '0; oo_r <= '0; om_r <= 1'b0; oe_r <= 1'b1; ol_r <= 1'b1;
          end else begin
            on_r <= 4'(cnt_r);
            oo_r <= mv_r[cnt_r[XW-1:0]] ? 4'(match_r[cnt_r[XW-1:0]]) : 4'd0;
            om_r <= mv_r[cnt_r[XW-1:0]];
            oe_r <= 1'b0;
            ol_r <= (cnt_r + IW'(1) == q_r);
            cnt_r <= cnt_r + IW'(1);
          end
        end
        default: ;
      endcase
    end
  end
endmodule

FILE: src/spa_checker.sv
// Port-level checker for sorted_pitch_alignment_dp, bound to the top level.
// Depends on the top level's ports only.
module spa_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_matched,
  input logic out_empty_res,
  input logic out_last,
  input logic [3:0] out_old_index
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_res |-> out_last && !out_matched) else $error("bad empty");
  a_unmatched: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_matched |-> out_old_index == 4'd0) else $error("old index");
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid || out_ready) else $error("ready while result waits");
endmodule

bind sorted_pitch_alignment_dp spa_checker u_spa_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_matched(out_matched),
  .out_empty_res(out_empty_res), .out_last(out_last), .out_old_index(out_old_index));

FILE: test/sorted_pitch_alignment_dp_test.sv
// Self-checking testbench for sorted_pitch_alignment_dp: random load/compute batches
// with random gaps on both sides, results checked against an in-bench alignment predictor.
// Depends on spa_pkg and the block's RTL.
`timescale 1ns / 1ps
module sorted_pitch_alignment_dp_test;
  import spa_pkg::*;

  typedef struct packed {
    logic [1:0] opcode;
    logic [15:0] pitch;
  } voice_item_t;

  typedef struct packed {
    logic [3:0] new_index;
    logic [3:0] old_index;
    logic matched;
    logic empty_res;
    logic last;
  } pairing_t;

  localparam int NV = 16;
  localparam int SZ = NV + 1;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_opcode = OP_LOAD_OLD;
  logic [15:0] in_pitch = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [3:0] out_new_index;
  logic [3:0] out_old_index;
  logic out_matched;
  logic out_empty_res;
  logic out_last;

  voice_item_t pending_items[$];
  pairing_t expected_pairings[$];
  int mismatch_count = 0;
  bit stimulus_done = 1'b0;
  bit in_taken = 1'b0;
  int in_gap = 0;
  int out_gap = 0;

  pitch_t old_pitches[NV];
  pitch_t new_pitches[NV];
  int old_n = 0;
  int new_n = 0;

  sorted_pitch_alignment_dp u_top (.*);

  always #6 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void sort_voices(input pitch_t p[NV], input int n, output int ord[NV]);
    int b;
    for (int a = 0; a < n; a++) begin
      b = a;
      while (b > 0 && p[ord[b - 1]] > p[a]) begin
        ord[b] = ord[b - 1];
        b--;
      end
      ord[b] = a;
    end
  endfunction

  task automatic predict_alignment(input voice_item_t it);
    int m, q, bm, bc, bp, cm, cc, d, i, j;
    int so[NV], sn[NV], match_of[NV];
    int cnt[SZ][SZ], cost[SZ][SZ], choice[SZ][SZ];
    bit have;
    pairing_t r;
    if (it.opcode == OP_LOAD_OLD) begin
      if (old_n < NV) begin
        old_pitches[old_n] = it.pitch;
        old_n++;
      end
    end else if (it.opcode == OP_LOAD_NEW) begin
      if (new_n < NV) begin
        new_pitches[new_n] = it.pitch;
        new_n++;
      end
    end else if (it.opcode == OP_COMPUTE) begin
      m = old_n;
      q = new_n;
      old_n = 0;
      new_n = 0;
      if (q == 0) begin
        r = '0;
        r.empty_res = 1'b1;
        r.last = 1'b1;
        expected_pairings.push_back(r);
        return;
      end
      for (int k = 0; k < NV; k++) match_of[k] = -1;
      if (m > 0) begin
        sort_voices(old_pitches, m, so);
        sort_voices(new_pitches, q, sn);
        for (i = m; i >= 0; i--) begin
          for (j = q; j >= 0; j--) begin
            if (i == m && j == q) begin
              cnt[i][j] = 0;
              cost[i][j] = 0;
              choice[i][j] = PICK_SKIP_OLD;
              continue;
            end
            have = 1'b0;
            bm = 0;
            bc = 0;
            bp = PICK_SKIP_OLD;
            if (i < m) begin
              bm = cnt[i + 1][j];
              bc = cost[i + 1][j];
              have = 1'b1;
            end
            if (j < q) begin
              cm = cnt[i][j + 1];
              cc = cost[i][j + 1];
              if (!have || cm > bm || (cm == bm && cc < bc)) begin
                bm = cm;
                bc = cc;
                bp = PICK_SKIP_NEW;
              end
            end
            if (i < m && j < q) begin
              d = int'(old_pitches[so[i]]) - int'(new_pitches[sn[j]]);
              if (d < 0) d = -d;
              cm = cnt[i + 1][j + 1] + 1;
              cc = cost[i + 1][j + 1] + d;
              if (cm > bm || (cm == bm && cc < bc)) begin
                bm = cm;
                bc = cc;
                bp = PICK_MATCH;
              end
            end
            cnt[i][j] = bm;
            cost[i][j] = bc;
            choice[i][j] = bp;
          end
        end
        i = 0;
        j = 0;
        while (i < m && j < q) begin
          if (choice[i][j] == PICK_SKIP_OLD) begin
            i++;
          end else if (choice[i][j] == PICK_SKIP_NEW) begin
            j++;
          end else begin
            match_of[sn[j]] = so[i];
            i++;
            j++;
          end
        end
      end
      for (int k = 0; k < q; k++) begin
        r = '0;
        r.new_index = 4'(k);
        r.matched = match_of[k] >= 0;
        r.old_index = match_of[k] >= 0 ? 4'(match_of[k]) : 4'd0;
        r.last = (k + 1 == q);
        expected_pairings.push_back(r);
      end
    end
  endtask

  function automatic pitch_t rand_pitch(input int style);
    case (style)
      0: return 16'($urandom_range(0, 65535));
      1: return 16'($urandom_range(16'h3C00, 16'h3C40));
      default: return 16'($urandom_range(0, 3) * 16'h4000 + $urandom_range(0, 3));
    endcase
  endfunction

  task automatic add_item(input logic [1:0] op, input pitch_t p);
    voice_item_t it;
    it.opcode = op;
    it.pitch = p;
    pending_items.push_back(it);
  endtask

  task automatic add_batch(input int n_old, input int n_new, input int style);
    int total;
    int a;
    int b;
    a = 0;
    b = 0;
    total = n_old + n_new;
    for (int k = 0; k < total; k++) begin
      if (b >= n_new || (a < n_old && $urandom_range(0, 1))) begin
        add_item(OP_LOAD_OLD, rand_pitch(style));
        a++;
      end else begin
        add_item(OP_LOAD_NEW, rand_pitch(style));
        b++;
      end
    end
    add_item(OP_COMPUTE, 16'($urandom_range(0, 65535)));
  endtask

  initial begin
    add_item(OP_COMPUTE, 16'hFFFF);
    add_item(OP_LOAD_NEW, 16'h0000);
    add_item(OP_LOAD_NEW, 16'hFFFF);
    add_item(OP_COMPUTE, 16'h0000);
    add_item(OP_LOAD_OLD, 16'hFFFF);
    add_item(OP_LOAD_OLD, 16'h0000);
    add_item(OP_LOAD_NEW, 16'h8000);
    add_item(OP_LOAD_NEW, 16'h8000);
    add_item(OP_LOAD_NEW, 16'h0001);
    add_item(OP_RESERVED, 16'h5555);
    add_item(OP_COMPUTE, 16'hAAAA);
    add_item(OP_LOAD_OLD, 16'h1234);
    add_item(OP_LOAD_OLD, 16'h1234);
    add_item(OP_LOAD_OLD, 16'h1234);
    add_item(OP_LOAD_NEW, 16'h1234);
    add_item(OP_COMPUTE, 16'h0000);
    add_item(OP_LOAD_OLD, 16'h0100);
    add_item(OP_COMPUTE, 16'h0000);
    add_batch(18, 18, 2);
    while (pending_items.size() < 370) begin
      case ($urandom_range(0, 9))
        0: add_batch(16, 16, $urandom_range(0, 2));
        1: add_item(OP_RESERVED, rand_pitch(0));
        2: add_batch($urandom_range(0, 2), $urandom_range(0, 2), 0);
        default: add_batch($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(0, 2));
      endcase
    end
    add_batch(NV, NV, 0);
  end

  always @(posedge clk) begin
    in_taken = rst_n && in_valid && in_ready;
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) begin
        predict_alignment(pending_items.pop_front());
        in_gap = pick_gap();
      end
      if (!in_valid || in_taken) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_valid <= 1'b1;
          in_opcode <= pending_items[0].opcode;
          in_pitch <= pending_items[0].pitch;
        end else begin
          in_valid <= 1'b0;
          stimulus_done = 1'b1;
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        out_gap = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    pairing_t got;
    pairing_t want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_new_index, out_old_index, out_matched, out_empty_res, out_last};
      if (expected_pairings.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("Unexpected transfer: got %p", got);
      end else begin
        want = expected_pairings.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("Transfer differs: expected %p, got %p", want, got);
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    wait (stimulus_done && expected_pairings.size() == 0);
    repeat (700) @(posedge clk);
    if (mismatch_count == 0 && expected_pairings.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end
endmodule
